@@ hdl/rth_pkg.sv @@
`default_nettype none

package rth_pkg;

    localparam int unsigned ChanW   = 8;
    localparam int unsigned SectW   = 11;
    localparam int unsigned HueNumW = 17;
    localparam int unsigned HueDivW = 9;
    localparam int unsigned SatNumW = 16;
    localparam int unsigned QuotW   = 8;
    localparam int unsigned DivSteps = 8;

    localparam logic [QuotW-1:0] HueCodeMax = 8'd254;
    localparam logic [7:0]       HueScale   = 8'd85;

    typedef struct packed {
        logic [HueNumW-1:0] hue_rem;
        logic [HueDivW-1:0] hue_div;
        logic [QuotW-1:0]   hue_q;
        logic               hue_zero;
        logic [SatNumW-1:0] sat_rem;
        logic [ChanW-1:0]   sat_div;
        logic [QuotW-1:0]   sat_q;
        logic               sat_zero;
        logic [ChanW-1:0]   val;
    } div_word_t;

endpackage

`default_nettype wire

@@ hdl/rth_front.sv @@
`default_nettype none

module rth_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic [7:0]               red,
    input  wire logic [7:0]               green,
    input  wire logic [7:0]               blue,
    output logic                          out_valid,
    output rth_pkg::div_word_t            out_word
);

    logic                               a_valid_reg;
    logic [rth_pkg::ChanW-1:0]          a_max_reg;
    logic [rth_pkg::ChanW-1:0]          a_diff_reg;
    logic [rth_pkg::SectW-1:0]          a_sect_reg;

    logic [rth_pkg::ChanW-1:0]          a_max_next;
    logic [rth_pkg::ChanW-1:0]          a_min_next;
    logic [rth_pkg::ChanW-1:0]          a_diff_next;
    logic [rth_pkg::SectW-1:0]          a_sect_next;
    logic [rth_pkg::SectW-1:0]          r_ext;
    logic [rth_pkg::SectW-1:0]          g_ext;
    logic [rth_pkg::SectW-1:0]          b_ext;
    logic [rth_pkg::SectW-1:0]          d_ext;

    logic                               b_valid_reg;
    rth_pkg::div_word_t                 b_word_reg;
    rth_pkg::div_word_t                 b_word_next;

    always_comb
    begin
        a_max_next = red;
        if (green > a_max_next)
        begin
            a_max_next = green;
        end
        if (blue > a_max_next)
        begin
            a_max_next = blue;
        end
        a_min_next = red;
        if (green < a_min_next)
        begin
            a_min_next = green;
        end
        if (blue < a_min_next)
        begin
            a_min_next = blue;
        end
        a_diff_next = a_max_next - a_min_next;
        r_ext = {3'b000, red};
        g_ext = {3'b000, green};
        b_ext = {3'b000, blue};
        d_ext = {3'b000, a_diff_next};
        // sector numerator in units of 60 degrees times diff
        if (a_max_next == red)
        begin
            if (green >= blue)
            begin
                a_sect_next = g_ext - b_ext;
            end
            else
            begin
                a_sect_next = (d_ext * 11'd6) - (b_ext - g_ext);
            end
        end
        else if (a_max_next == green)
        begin
            a_sect_next = (d_ext << 1) + b_ext - r_ext;
        end
        else
        begin
            a_sect_next = (d_ext << 2) + r_ext - g_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_max_reg  <= a_max_next;
        a_diff_reg <= a_diff_next;
        a_sect_reg <= a_sect_next;
    end

    always_comb
    begin
        b_word_next          = '0;
        b_word_next.hue_rem  = {6'b0, a_sect_reg} * {9'b0, rth_pkg::HueScale};
        b_word_next.hue_div  = {a_diff_reg, 1'b0};
        b_word_next.hue_q    = '0;
        b_word_next.hue_zero = (a_diff_reg == '0);
        b_word_next.sat_rem  = {a_diff_reg, 8'b0} - {8'b0, a_diff_reg};
        b_word_next.sat_div  = a_max_reg;
        b_word_next.sat_q    = '0;
        b_word_next.sat_zero = (a_max_reg == '0);
        b_word_next.val      = a_max_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_word_reg <= b_word_next;
    end

    assign out_valid = b_valid_reg;
    assign out_word  = b_word_reg;

endmodule

`default_nettype wire

@@ hdl/rth_div_stage.sv @@
`default_nettype none

module rth_div_stage #(
    parameter int unsigned Shift = 0
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire rth_pkg::div_word_t       in_word,
    output logic                          out_valid,
    output rth_pkg::div_word_t            out_word
);

    logic                          valid_reg;
    rth_pkg::div_word_t            word_reg;
    rth_pkg::div_word_t            word_next;
    logic [rth_pkg::HueNumW-1:0]   hue_trial;
    logic [rth_pkg::SatNumW-1:0]   sat_trial;
    logic [rth_pkg::QuotW-1:0]     qbit;

    always_comb
    begin
        hue_trial = {{(rth_pkg::HueNumW - rth_pkg::HueDivW){1'b0}}, in_word.hue_div} << Shift;
        sat_trial = {{(rth_pkg::SatNumW - rth_pkg::ChanW){1'b0}}, in_word.sat_div} << Shift;
        qbit      = {{(rth_pkg::QuotW - 1){1'b0}}, 1'b1} << Shift;
        word_next = in_word;
        if (in_word.hue_rem >= hue_trial)
        begin
            word_next.hue_rem = in_word.hue_rem - hue_trial;
            word_next.hue_q   = in_word.hue_q | qbit;
        end
        if (in_word.sat_rem >= sat_trial)
        begin
            word_next.sat_rem = in_word.sat_rem - sat_trial;
            word_next.sat_q   = in_word.sat_q | qbit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

@@ hdl/rgb_to_hsv_byte_pixel.sv @@
// Pipeline: 2 front stages, 8 divide stages, 1 output stage from start to done.
// Throughput: one pixel per clock; busy is always low, one restoring quotient bit per stage.
// Reset: rst_n clears all valid bits at once; results in flight are dropped.
// The receiver cannot stall; each result shows for one cycle with done high.
`default_nettype none

module rgb_to_hsv_byte_pixel (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    output logic             done,
    output logic [7:0]       hue_code,
    output logic [7:0]       sat_code,
    output logic [7:0]       val_code
);

    logic                 pipe_valid [rth_pkg::DivSteps+1];
    rth_pkg::div_word_t   pipe_word  [rth_pkg::DivSteps+1];

    logic                 done_reg;
    logic [7:0]           hue_reg;
    logic [7:0]           sat_reg;
    logic [7:0]           val_reg;
    logic [7:0]           hue_next;
    logic [7:0]           sat_next;
    rth_pkg::div_word_t   last_word;

    assign busy = 1'b0;

    rth_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (pipe_valid[0]),
        .out_word  (pipe_word[0])
    );

    for (genvar i = 0; i < rth_pkg::DivSteps; i++)
    begin : g_div
        rth_div_stage #(
            .Shift (rth_pkg::DivSteps - 1 - i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[i]),
            .in_word   (pipe_word[i]),
            .out_valid (pipe_valid[i+1]),
            .out_word  (pipe_word[i+1])
        );
    end

    always_comb
    begin
        last_word = pipe_word[rth_pkg::DivSteps];
        if (last_word.hue_zero)
        begin
            hue_next = '0;
        end
        else if (last_word.hue_q > rth_pkg::HueCodeMax)
        begin
            hue_next = rth_pkg::HueCodeMax;
        end
        else
        begin
            hue_next = last_word.hue_q;
        end
        sat_next = last_word.sat_zero ? '0 : last_word.sat_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pipe_valid[rth_pkg::DivSteps];
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg <= hue_next;
        sat_reg <= sat_next;
        val_reg <= last_word.val;
    end

    assign done     = done_reg;
    assign hue_code = hue_reg;
    assign sat_code = sat_reg;
    assign val_code = val_reg;

endmodule

`default_nettype wire
